FILE: hdl/playfair_encrypt_top_macros.svh
// assertion macros for the playfair encryption block
// used by the port checker; depends on nothing
`ifndef PLAYFAIR_ENCRYPT_TOP_MACROS_SVH
`define PLAYFAIR_ENCRYPT_TOP_MACROS_SVH

// condition now implies condition at the next clock
`define PFE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("playfair port check failed");

// condition now implies condition in the same clock
`define PFE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("playfair port check failed");

`endif

FILE: hdl/pfe_pkg.sv
// shared types, codes and square arithmetic for the playfair block
// no dependencies
package pfe_pkg;

  localparam logic [1:0] CMD_KEY      = 2'd0;
  localparam logic [1:0] CMD_KEY_END  = 2'd1;
  localparam logic [1:0] CMD_TEXT     = 2'd2;
  localparam logic [1:0] CMD_TEXT_END = 2'd3;

  localparam logic [4:0] LETTER_I    = 5'd8;
  localparam logic [4:0] LETTER_J    = 5'd9;
  localparam logic [4:0] LETTER_X    = 5'd23;
  localparam logic [4:0] LAST_LETTER = 5'd25;
  localparam logic [4:0] SQ_CELLS    = 5'd25;
  localparam logic [2:0] SQ_LAST_IDX = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_MAP,
    ST_EMIT0,
    ST_EMIT1
  } pfe_state_t;

  typedef struct packed {
    logic key_write;
    logic fill_start;
    logic fill_step;
    logic arm;
    logic pend_load;
    logic pend_clear;
    logic pair_start;
    logic pair_use_x;
    logic sq_read;
    logic emit_second;
  } pfe_cmd_t;

  typedef struct packed {
    logic key_ready;
    logic pend_valid;
    logic letter_ok;
    logic letter_eq;
    logic fill_last;
  } pfe_status_t;

  function automatic logic [4:0] fold_letter(input logic [4:0] l);
    return (l == LETTER_J) ? LETTER_I : l;
  endfunction

  function automatic logic [2:0] row_of(input logic [4:0] p);
    logic [2:0] r;
    priority if (p >= 5'd20) r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5) r = 3'd1;
    else r = 3'd0;
    return r;
  endfunction

  function automatic logic [2:0] col_of(input logic [4:0] p);
    logic [4:0] c;
    c = p - {row_of(p), 2'b00} - {2'b00, row_of(p)};
    return c[2:0];
  endfunction

  function automatic logic [2:0] inc_mod5(input logic [2:0] v);
    return (v == SQ_LAST_IDX) ? 3'd0 : v + 3'd1;
  endfunction

  function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
    return {r, 2'b00} + {2'b00, r} + {2'b00, c};
  endfunction

endpackage

FILE: hdl/pfe_ctrl.sv
// controller state machine for the playfair block
// depends on pfe_pkg
module pfe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [1:0]          in_cmd,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  pfe_pkg::pfe_status_t status_i,
  output pfe_pkg::pfe_cmd_t    cmd_o
);
  import pfe_pkg::*;

  pfe_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_o.fill_start) state_nxt = ST_FILL;
        else if (cmd_o.pair_start) state_nxt = ST_MAP;
      end
      ST_FILL: begin
        if (status_i.fill_last) state_nxt = ST_IDLE;
      end
      ST_MAP: state_nxt = ST_EMIT0;
      ST_EMIT0: begin
        if (!out_stall) state_nxt = ST_EMIT1;
      end
      ST_EMIT1: begin
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    in_stall  = (state_r != ST_IDLE);
    out_valid = (state_r == ST_EMIT0) || (state_r == ST_EMIT1);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd)
            CMD_KEY: begin
              cmd_o.key_write = !status_i.key_ready && status_i.letter_ok;
            end
            CMD_KEY_END: begin
              cmd_o.fill_start = !status_i.key_ready;
            end
            CMD_TEXT: begin
              if (status_i.key_ready && status_i.letter_ok) begin
                if (!status_i.pend_valid) begin
                  cmd_o.pend_load = 1'b1;
                end else if (status_i.letter_eq) begin
                  cmd_o.pair_start = 1'b1;
                  cmd_o.pair_use_x = 1'b1;
                end else begin
                  cmd_o.pair_start = 1'b1;
                  cmd_o.pend_clear = 1'b1;
                end
              end
            end
            CMD_TEXT_END: begin
              if (status_i.key_ready && status_i.pend_valid) begin
                cmd_o.pair_start = 1'b1;
                cmd_o.pair_use_x = 1'b1;
                cmd_o.pend_clear = 1'b1;
              end
            end
            default: cmd_o = '0;
          endcase
        end
      end
      ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        cmd_o.arm       = status_i.fill_last;
      end
      ST_MAP: cmd_o.sq_read = 1'b1;
      ST_EMIT0: cmd_o.emit_second = 1'b0;
      ST_EMIT1: cmd_o.emit_second = 1'b1;
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: hdl/pfe_datapath.sv
// key square, letter positions, pairing state and cipher lookup
// depends on pfe_pkg
module pfe_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [4:0]           in_letter,
  input  pfe_pkg::pfe_cmd_t    cmd_i,
  output pfe_pkg::pfe_status_t status_o,
  output logic [4:0]           cipher_letter
);
  import pfe_pkg::*;

  logic [4:0]  square_mem [25];
  logic [4:0]  pos_mem    [26];
  logic [25:0] used_r;
  logic [4:0]  fill_cnt_r;
  logic [4:0]  key_idx_r;
  logic [4:0]  pend_r;
  logic        pend_valid_r;
  logic        key_ready_r;
  logic [4:0]  pos_a_r, pos_b_r;
  logic [4:0]  sq_a_r, sq_b_r;

  logic [4:0] in_fold;
  logic [4:0] place_addr;
  logic       place_en;
  logic [4:0] rd_b;
  logic [2:0] ra, ca, rb, cb;
  logic [4:0] qa, qb;

  assign in_fold    = fold_letter(in_letter);
  assign place_addr = cmd_i.fill_step ? key_idx_r : in_fold;
  assign place_en   = (cmd_i.key_write || cmd_i.fill_step) && (place_addr != LETTER_J) &&
                      !used_r[place_addr] && (fill_cnt_r < SQ_CELLS);
  assign rd_b       = cmd_i.pair_use_x ? LETTER_X : in_fold;

  assign status_o.key_ready  = key_ready_r;
  assign status_o.pend_valid = pend_valid_r;
  assign status_o.letter_ok  = (in_letter <= LAST_LETTER);
  assign status_o.letter_eq  = (in_fold == pend_r);
  assign status_o.fill_last  = (key_idx_r == LAST_LETTER);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      fill_cnt_r   <= '0;
      key_idx_r    <= '0;
      pend_r       <= '0;
      pend_valid_r <= 1'b0;
      key_ready_r  <= 1'b0;
    end else begin
      if (place_en) begin
        used_r[place_addr] <= 1'b1;
        fill_cnt_r         <= fill_cnt_r + 5'd1;
      end
      if (cmd_i.fill_start) key_idx_r <= '0;
      else if (cmd_i.fill_step) key_idx_r <= key_idx_r + 5'd1;
      if (cmd_i.arm) key_ready_r <= 1'b1;
      if (cmd_i.pend_load) begin
        pend_r       <= in_fold;
        pend_valid_r <= 1'b1;
      end else if (cmd_i.pend_clear) begin
        pend_valid_r <= 1'b0;
      end
    end
  end

  // position table, read at both pair letters
  always_ff @(posedge clk) begin
    if (place_en) pos_mem[place_addr] <= fill_cnt_r;
    if (cmd_i.pair_start) begin
      pos_a_r <= pos_mem[pend_r];
      pos_b_r <= pos_mem[rd_b];
    end
  end

  always_comb begin
    ra = row_of(pos_a_r);
    ca = col_of(pos_a_r);
    rb = row_of(pos_b_r);
    cb = col_of(pos_b_r);
    priority if (ra == rb) begin
      qa = cell_of(ra, inc_mod5(ca));
      qb = cell_of(rb, inc_mod5(cb));
    end else if (ca == cb) begin
      qa = cell_of(inc_mod5(ra), ca);
      qb = cell_of(inc_mod5(rb), cb);
    end else begin
      qa = cell_of(ra, cb);
      qb = cell_of(rb, ca);
    end
  end

  // key square, read at both cipher cells
  always_ff @(posedge clk) begin
    if (place_en) square_mem[fill_cnt_r] <= place_addr;
    if (cmd_i.sq_read) begin
      sq_a_r <= square_mem[qa];
      sq_b_r <= square_mem[qb];
    end
  end

  assign cipher_letter = cmd_i.emit_second ? sq_b_r : sq_a_r;

endmodule

FILE: hdl/playfair_encrypt_top.sv
// top level of the playfair encryption block
// depends on pfe_pkg, pfe_ctrl and pfe_datapath
//
//   channel   signals                               direction
//   in        in_valid in_stall in_cmd in_letter     into block
//   out       out_valid out_stall out_cipher_letter  out of block
//             out_pair_last
//
// one transaction at a time: key letter, text letter without a pair and ignored
// items are handled in the idle state; a pair passes position read, square lookup and
// two output states, held under out_stall, set by the registered table reads.
// key end walks the alphabet, writing each letter not yet placed into the tables.
// rst_n is synchronous; square and position tables are not cleared.
// in_stall is high from accepting a pair or key end until its work is done.
module playfair_encrypt_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [4:0] in_letter,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [4:0] out_cipher_letter,
  output logic       out_pair_last
);
  import pfe_pkg::*;

  pfe_cmd_t    cmd;
  pfe_status_t status;

  pfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  pfe_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_letter     (in_letter),
    .cmd_i         (cmd),
    .status_o      (status),
    .cipher_letter (out_cipher_letter)
  );

  assign out_pair_last = cmd.emit_second;

endmodule

FILE: hdl/pfe_checker.sv
// port checker for the playfair encryption block, bound to the top level
// depends on playfair_encrypt_top_macros.svh
`include "playfair_encrypt_top_macros.svh"

module pfe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [4:0] out_cipher_letter,
  input logic       out_pair_last
);

  logic [5:0] out_word;

  assign out_word = {out_pair_last, out_cipher_letter};

  `PFE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))
  `PFE_ASSERT_NEXT(a_pair_second, out_valid && !out_stall && !out_pair_last, out_valid && out_pair_last)
  `PFE_ASSERT_NOW(a_no_accept_emit, out_valid, in_stall)
  `PFE_ASSERT_NOW(a_letter_range, out_valid, out_cipher_letter <= 5'd25)

endmodule

bind playfair_encrypt_top pfe_checker u_pfe_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_cipher_letter (out_cipher_letter),
  .out_pair_last     (out_pair_last)
);

FILE: test/pfe_cipher_checker.sv
// checker for the playfair encryption block: tracks the key square and open pair,
// predicts cipher letters and compares them with the result channel
// depends on pfe_pkg
`timescale 1ns / 100ps

module pfe_cipher_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [4:0]  in_letter,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [4:0]  out_cipher_letter,
  input  logic        out_pair_last,
  output int unsigned mismatches,
  output int unsigned waiting
);
  import pfe_pkg::*;

  logic [4:0] key_sq [25];
  logic [4:0] letter_cell [26];
  logic       placed [26];
  int         next_cell;
  logic [4:0] open_letter;
  logic       open_pair;
  logic       armed;

  // {pair_last, cipher_letter}, oldest first
  logic [5:0] cipher_q [$];

  initial begin
    mismatches = 0;
    waiting = 0;
  end

  function automatic logic [4:0] fold_j(input logic [4:0] l);
    return (l == LETTER_J) ? LETTER_I : l;
  endfunction

  task automatic place_in_square(input logic [4:0] l);
    if (l > LAST_LETTER || l == LETTER_J || placed[l] || next_cell >= 25) return;
    key_sq[next_cell] = l;
    letter_cell[l] = 5'(next_cell);
    placed[l] = 1'b1;
    next_cell++;
  endtask

  task automatic encipher_digraph(input logic [4:0] a, input logic [4:0] b);
    int pa, pb, ra, ca, rb, cb, qa, qb;
    pa = letter_cell[a];
    pb = letter_cell[b];
    ra = pa / 5;
    ca = pa % 5;
    rb = pb / 5;
    cb = pb % 5;
    if (ra == rb) begin
      qa = ra * 5 + (ca + 1) % 5;
      qb = rb * 5 + (cb + 1) % 5;
    end else if (ca == cb) begin
      qa = ((ra + 1) % 5) * 5 + ca;
      qb = ((rb + 1) % 5) * 5 + cb;
    end else begin
      qa = ra * 5 + cb;
      qb = rb * 5 + ca;
    end
    cipher_q.push_back({1'b0, key_sq[qa]});
    cipher_q.push_back({1'b1, key_sq[qb]});
  endtask

  task automatic predict_item(input logic [1:0] cmd, input logic [4:0] raw);
    logic [4:0] l;
    l = fold_j(raw);
    case (cmd)
      CMD_KEY: begin
        if (!armed && raw <= LAST_LETTER) place_in_square(l);
      end
      CMD_KEY_END: begin
        if (!armed) begin
          for (int k = 0; k < 26; k++) place_in_square(5'(k));
          armed = 1'b1;
        end
      end
      CMD_TEXT: begin
        if (armed && raw <= LAST_LETTER) begin
          if (!open_pair) begin
            open_letter = l;
            open_pair = 1'b1;
          end else if (l == open_letter) begin
            // doubled letter: x goes between, the letter stays open
            encipher_digraph(open_letter, LETTER_X);
          end else begin
            encipher_digraph(open_letter, l);
            open_pair = 1'b0;
          end
        end
      end
      default: begin
        if (armed && open_pair) begin
          encipher_digraph(open_letter, LETTER_X);
          open_pair = 1'b0;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    logic [5:0] exp_res;
    if (!rst_n) begin
      for (int k = 0; k < 26; k++) placed[k] = 1'b0;
      next_cell = 0;
      open_letter = '0;
      open_pair = 1'b0;
      armed = 1'b0;
      cipher_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (cipher_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, actual letter %0d last %0b",
                   $time, out_cipher_letter, out_pair_last);
        end else begin
          exp_res = cipher_q.pop_front();
          if (exp_res[4:0] !== out_cipher_letter || exp_res[5] !== out_pair_last) begin
            mismatches++;
            $display("%0t: result mismatch: expected letter %0d last %0b, actual letter %0d last %0b",
                     $time, exp_res[4:0], exp_res[5], out_cipher_letter, out_pair_last);
          end
        end
      end
      if (in_valid && !in_stall) predict_item(in_cmd, in_letter);
    end
    waiting = cipher_q.size();
  end

endmodule

FILE: test/tb_top.sv
// testbench top for the playfair encryption block: clock, reset, stimulus and verdict
// depends on pfe_pkg, playfair_encrypt_top and pfe_cipher_checker
`timescale 1ns / 100ps

module tb_top;
  import pfe_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_cmd;
  logic [4:0] in_letter;
  logic       out_valid;
  logic       out_stall;
  logic [4:0] out_cipher_letter;
  logic       out_pair_last;

  int unsigned mismatches;
  int unsigned waiting;

  logic gaps_on = 1'b1;
  logic stall_on = 1'b1;
  logic hold_req = 1'b0;
  int   hold_left = 0;
  int   stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  playfair_encrypt_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_letter         (in_letter),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cipher_letter (out_cipher_letter),
    .out_pair_last     (out_pair_last)
  );

  pfe_cipher_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_letter         (in_letter),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cipher_letter (out_cipher_letter),
    .out_pair_last     (out_pair_last),
    .mismatches        (mismatches),
    .waiting           (waiting)
  );

  task automatic send_item(input logic [1:0] cmd, input logic [4:0] letter);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_letter <= letter;
    do @(posedge clk); while (in_stall);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
  endtask

  // result side: random short stalls, plus one long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    string      key_word;
    int         counted;
    int         pick;
    logic [1:0] cmd;
    logic [4:0] ltr;
    logic [4:0] last_text;
    logic       held;
    logic       paused;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_KEY;
    in_letter = '0;
    counted = 0;
    last_text = LETTER_X;
    held = 1'b0;
    paused = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // text before the key is armed is dropped
    send_item(CMD_TEXT, 5'd0);
    send_item(CMD_TEXT_END, 5'd0);
    // key with a repeated letter and j folded onto i
    key_word = "playfairj";
    for (int k = 0; k < key_word.len(); k++) send_item(CMD_KEY, 5'(key_word[k] - 8'd97));
    send_item(CMD_KEY, 5'd31);
    send_item(CMD_KEY_END, 5'd0);
    // square is frozen once armed
    send_item(CMD_KEY, 5'd1);
    send_item(CMD_KEY_END, 5'd0);
    send_item(CMD_TEXT_END, 5'd0);
    // doubled x, then j against i, then the alphabet ends
    send_item(CMD_TEXT, LETTER_X);
    send_item(CMD_TEXT, LETTER_X);
    send_item(CMD_TEXT_END, 5'd0);
    send_item(CMD_TEXT, LETTER_J);
    send_item(CMD_TEXT, LETTER_I);
    send_item(CMD_TEXT, 5'd30);
    send_item(CMD_TEXT, 5'd0);
    send_item(CMD_TEXT, LAST_LETTER);
    send_item(CMD_TEXT, LAST_LETTER);
    send_item(CMD_TEXT_END, 5'd0);

    while (counted < 700) begin
      if (counted == 200 && !held) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      if (counted == 400 && !paused) begin
        drain_results();
        paused = 1'b1;
      end
      if (counted >= 600) begin
        gaps_on = 1'b0;
        stall_on = 1'b0;
      end
      pick = $urandom_range(0, 99);
      cmd = CMD_TEXT;
      ltr = 5'($urandom_range(0, 31));
      if (pick < 20) ltr = last_text;
      else if (pick < 78) ltr = 5'($urandom_range(0, 25));
      else if (pick < 84) ltr = pick[0] ? LETTER_X : LETTER_J;
      else if (pick < 90) cmd = CMD_TEXT_END;
      else if (pick < 94) ltr = 5'($urandom_range(26, 31));
      else if (pick < 97) cmd = CMD_KEY;
      else cmd = CMD_KEY_END;
      if (cmd == CMD_TEXT && ltr <= LAST_LETTER) last_text = ltr;
      counted++;
      send_item(cmd, ltr);
    end
    send_item(CMD_TEXT_END, 5'd0);

    drain_results();
    repeat (30) @(posedge clk);
    if (mismatches == 0 && waiting == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
